/* sv/hte_pkg.sv */
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants for the Huffman table encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

	localparam int NUM_SYMBOLS   = 256;
	localparam int SYM_W         = 8;
	localparam int CODE_W        = 32;
	localparam int LEN_W         = 6;
	localparam int BYTE_W        = 8;
	localparam int ACC_W         = CODE_W + BYTE_W;
	localparam int DEF_MAX_LEN   = 32;
	localparam int DEF_Q_DEPTH   = 4;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FLUSH  = 2'd2
	} req_type_t;

	// One request waiting for the bit packer: either a flush or an encode
	// whose code is already left aligned in the word.
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hte_entry_t;

endpackage

/* sv/huffman_table_encoder.sv */
// ----------------------------------------------------------------------------
// huffman_table_encoder
// Usage: requests enter through push/full, results leave through empty/pop.
// A load request writes one symbol's code and length into the 256-entry
// table and gives no result. An encode request appends the symbol's code to
// the bit stream and gives one result for each completed byte (up to four),
// the final one marked by last. A flush request always gives one result
// with flush_done set, carrying the zero-padded partial byte if any bits
// were pending. A result passes from the intake register through the queue
// into the result register, from which it is popped. Requests are taken
// one per cycle while full is low; the bit packer emits one byte per cycle
// while the result register is free, and the queue between table lookup
// and packer (four entries by default) absorbs bursts. Reset clears the
// loaded flags of the table, so no symbol is loaded afterwards, and
// empties the bit stream and all queues. When pop is held low the result
// register, then the queue, then the intake fill up and full rises.
// ----------------------------------------------------------------------------
module huffman_table_encoder import hte_pkg::*; #(
	parameter int MAX_CODE_LEN = DEF_MAX_LEN,
	parameter int QUEUE_DEPTH  = DEF_Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [2:0]        pad_count,
	output logic              flush_done,
	output logic              last
);

	logic       enq;
	hte_entry_t enq_entry;
	logic       q_full;
	logic       rd;
	hte_entry_t head;
	logic       q_empty;

	hte_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.symbol    (symbol),
		.code_bits (code_bits),
		.code_len  (code_len),
		.enq       (enq),
		.enq_entry (enq_entry),
		.q_full    (q_full)
	);

	hte_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (enq),
		.wr_entry (enq_entry),
		.q_full   (q_full),
		.rd       (rd),
		.head     (head),
		.q_empty  (q_empty)
	);

	hte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.rd         (rd),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.pad_count  (pad_count),
		.flush_done (flush_done),
		.last       (last)
	);

endmodule

/* sv/hte_front.sv */
// ----------------------------------------------------------------------------
// hte_front
// Request intake: code table storage, table lookup and classification of
// requests into work for the bit packer.
// ----------------------------------------------------------------------------
module hte_front import hte_pkg::*; #(
	parameter int MAX_CODE_LEN = DEF_MAX_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	output logic              enq,
	output hte_entry_t        enq_entry,
	input  logic              q_full
);

	localparam logic [LEN_W-1:0] LEN_LIM =
		LEN_W'((MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN);

	logic [CODE_W-1:0]      code_mem [NUM_SYMBOLS];
	logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] len_vld_q;

	logic              vld_s1;
	logic              flush_s1;
	logic [CODE_W-1:0] code_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              lv_s1;

	logic              accept;
	logic              is_load;
	logic              needs_work;
	logic [LEN_W-1:0]  len_raw;
	logic [LEN_W-1:0]  len_eff;
	logic              need_enq;
	logic              stall;

	always_comb begin
		is_load    = 1'b0;
		needs_work = 1'b0;
		unique case (req_type)
			REQ_LOAD:   is_load    = 1'b1;
			REQ_ENCODE: needs_work = 1'b1;
			REQ_FLUSH:  needs_work = 1'b1;
			default: begin
				is_load    = 1'b0;
				needs_work = 1'b0;
			end
		endcase
	end

	always_comb begin
		len_raw  = lv_s1 ? len_s1 : '0;
		len_eff  = (len_raw > LEN_LIM) ? LEN_LIM : len_raw;
		need_enq = flush_s1 || (len_eff != '0);
		stall    = vld_s1 && need_enq && q_full;
		full     = stall;
		accept   = push && !full;
		enq      = vld_s1 && need_enq && !q_full;
		enq_entry.flush = flush_s1;
		enq_entry.code  = code_s1 << (LEN_W'(CODE_W) - len_eff);
		enq_entry.len   = flush_s1 ? '0 : len_eff;
	end

	// Table storage: written by loads, read at the symbol of every request.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_load) begin
				code_mem[symbol] <= code_bits;
				len_mem[symbol]  <= code_len;
			end
			code_s1 <= code_mem[symbol];
			len_s1  <= len_mem[symbol];
		end
	end

	// An entry never loaded since reset reads as length zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
			lv_s1     <= 1'b0;
			vld_s1    <= 1'b0;
			flush_s1  <= 1'b0;
		end else begin
			if (accept) begin
				if (is_load) begin
					len_vld_q[symbol] <= 1'b1;
				end
				lv_s1    <= len_vld_q[symbol];
				vld_s1   <= needs_work;
				flush_s1 <= (req_type == REQ_FLUSH);
			end else if (!stall) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

/* sv/hte_queue.sv */
// ----------------------------------------------------------------------------
// hte_queue
// Short first-in first-out queue between the intake and the bit packer.
// ----------------------------------------------------------------------------
module hte_queue import hte_pkg::*; #(
	parameter int DEPTH = DEF_Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  hte_entry_t wr_entry,
	output logic       q_full,
	input  logic       rd,
	output hte_entry_t head,
	output logic       q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hte_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	always_comb begin
		q_full  = (cnt_q == CNT_W'(DEPTH));
		q_empty = (cnt_q == '0);
		do_wr   = wr && !q_full;
		do_rd   = rd && !q_empty;
		head    = slot_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/hte_back.sv */
// ----------------------------------------------------------------------------
// hte_back
// Bit packer: appends codes to a left-aligned accumulator, emits one byte a
// cycle into the result register while it is free, and answers flush requests.
// ----------------------------------------------------------------------------
module hte_back import hte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hte_entry_t        head,
	input  logic              q_empty,
	output logic              rd,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [2:0]        pad_count,
	output logic              flush_done,
	output logic              last
);

	// Pending bits sit at the top of the accumulator; every bit below the
	// valid ones is kept at zero.
	logic [ACC_W-1:0]  acc_q;
	logic [LEN_W-1:0]  tot_q;

	logic              out_vld_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bv_q;
	logic [2:0]        out_pad_q;
	logic              out_done_q;
	logic              out_last_q;

	logic              out_free;
	logic              draining;
	logic [ACC_W-1:0]  merged;
	logic [LEN_W-1:0]  new_tot;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_bv;
	logic [2:0]        emit_pad;
	logic              emit_done;
	logic              emit_last;
	logic [ACC_W-1:0]  acc_d;
	logic [LEN_W-1:0]  tot_d;

	always_comb begin
		out_free  = !out_vld_q || pop;
		draining  = (tot_q >= LEN_W'(BYTE_W));
		merged    = acc_q | ({head.code, {BYTE_W{1'b0}}} >> tot_q[2:0]);
		new_tot   = tot_q + head.len;
		rd        = 1'b0;
		emit      = 1'b0;
		emit_byte = acc_q[ACC_W-1 -: BYTE_W];
		emit_bv   = 1'b1;
		emit_pad  = '0;
		emit_done = 1'b0;
		emit_last = 1'b0;
		acc_d     = acc_q;
		tot_d     = tot_q;
		if (draining) begin
			if (out_free) begin
				emit      = 1'b1;
				emit_last = (tot_q < LEN_W'(2 * BYTE_W));
				acc_d     = acc_q << BYTE_W;
				tot_d     = tot_q - LEN_W'(BYTE_W);
			end
		end else if (!q_empty) begin
			if (head.flush) begin
				if (out_free) begin
					rd        = 1'b1;
					emit      = 1'b1;
					emit_bv   = (tot_q != '0);
					emit_pad  = 3'(4'(BYTE_W) - 4'(tot_q));
					emit_done = 1'b1;
					emit_last = 1'b1;
					acc_d     = '0;
					tot_d     = '0;
				end
			end else begin
				rd = 1'b1;
				if ((new_tot >= LEN_W'(BYTE_W)) && out_free) begin
					emit      = 1'b1;
					emit_byte = merged[ACC_W-1 -: BYTE_W];
					emit_last = (new_tot < LEN_W'(2 * BYTE_W));
					acc_d     = merged << BYTE_W;
					tot_d     = new_tot - LEN_W'(BYTE_W);
				end else begin
					acc_d = merged;
					tot_d = new_tot;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			tot_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			tot_q <= tot_d;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_bv_q   <= emit_bv;
			out_pad_q  <= emit_pad;
			out_done_q <= emit_done;
			out_last_q <= emit_last;
		end
	end

	assign empty      = !out_vld_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = out_bv_q;
	assign pad_count  = out_pad_q;
	assign flush_done = out_done_q;
	assign last       = out_last_q;

endmodule

/* test/tb_huffman_table_encoder.sv */
// ----------------------------------------------------------------------------
// tb_huffman_table_encoder
// Self-checking bench for the Huffman table encoder. Load, encode, flush and
// ignored requests are sent through the push/full side in random bursts, while
// the pop side stalls on its own pattern. A local bit packer predicts every
// output byte, and each popped result is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_huffman_table_encoder;
	import hte_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 3;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 120;
	localparam int RAND_ROUNDS  = 5;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [2:0] pad;
		logic       done;
		logic       lst;
	} out_word_t;

	typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [1:0]        req_type = REQ_LOAD;
	logic [SYM_W-1:0]  symbol = '0;
	logic [CODE_W-1:0] code_bits = '0;
	logic [LEN_W-1:0]  code_len = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic [2:0]        pad_count;
	logic              flush_done;
	logic              last;

	// Predictor state: the code table and the bit accumulator.
	logic [CODE_W-1:0] code_tbl [NUM_SYMBOLS];
	logic [LEN_W-1:0]  len_tbl [NUM_SYMBOLS];
	logic [6:0]        acc_bits = '0;
	logic [2:0]        acc_count = '0;

	out_word_t byte_q [$];
	int        loaded_syms [$];
	int        errors = 0;
	int        burst_left = 0;
	bit        hold_request = 0;

	huffman_table_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.pad_count  (pad_count),
		.flush_done (flush_done),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			len_tbl[i] = '0;
			code_tbl[i] = '0;
		end
	end

	// Works out the bytes that one accepted request produces.
	function automatic void predict_packer(logic [1:0] req, logic [7:0] sym,
			logic [31:0] code, logic [5:0] len);
		int        eff;
		int        total;
		int        nbytes;
		logic [63:0] acc;
		out_word_t w;
		case (req)
			REQ_LOAD: begin
				code_tbl[sym] = code;
				len_tbl[sym] = len;
			end
			REQ_ENCODE: begin
				eff = len_tbl[sym];
				if (eff > DEF_MAX_LEN)
					eff = DEF_MAX_LEN;
				if (eff > CODE_W)
					eff = CODE_W;
				if (eff != 0) begin
					acc = ({57'd0, acc_bits} << eff) |
						({32'd0, code_tbl[sym]} & ((64'd1 << eff) - 64'd1));
					total = acc_count + eff;
					nbytes = total / 8;
					for (int k = 1; k <= nbytes; k++) begin
						total -= 8;
						w.data = 8'(acc >> total);
						w.valid = 1'b1;
						w.pad = 3'd0;
						w.done = 1'b0;
						w.lst = (k == nbytes);
						byte_q.insert(byte_q.size(), w);
					end
					acc_bits = 7'(acc & ((64'd1 << total) - 64'd1));
					acc_count = 3'(total);
				end
			end
			REQ_FLUSH: begin
				if (acc_count != 0) begin
					w.pad = 3'(8 - acc_count);
					w.data = 8'({1'b0, acc_bits} << w.pad);
					w.valid = 1'b1;
				end else begin
					w.pad = 3'd0;
					w.data = 8'd0;
					w.valid = 1'b0;
				end
				w.done = 1'b1;
				w.lst = 1'b1;
				byte_q.insert(byte_q.size(), w);
				acc_bits = '0;
				acc_count = '0;
			end
			default: ;
		endcase
	endfunction

	// Offers one request and holds it until taken; the sender then either
	// carries on with its burst or drops push for a random gap.
	task automatic send_request(logic [1:0] req, logic [7:0] sym,
			logic [31:0] code, logic [5:0] len);
		int gap;
		push <= 1'b1;
		req_type <= req;
		symbol <= sym;
		code_bits <= code;
		code_len <= len;
		do @(posedge clk); while (full);
		predict_packer(req, sym, code, len);
		if (req == REQ_LOAD && len != 0)
			loaded_syms.insert(loaded_syms.size(), sym);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic load_symbol(logic [7:0] sym, logic [31:0] code, logic [5:0] len);
		send_request(REQ_LOAD, sym, code, len);
	endtask

	task automatic encode_symbol(logic [7:0] sym);
		send_request(REQ_ENCODE, sym, $urandom, 6'($urandom));
	endtask

	task automatic flush_stream();
		send_request(REQ_FLUSH, 8'($urandom), $urandom, 6'($urandom));
	endtask

	// Empty table, empty flush, extreme and overlong lengths, unused entries,
	// the ignored request type and flushes with and without pending bits.
	task automatic test_directed();
		encode_symbol(8'h00);
		flush_stream();
		load_symbol(8'h00, 32'h0000_0001, 6'd1);
		load_symbol(8'hFF, 32'hFFFF_FFFF, 6'd32);
		load_symbol(8'h80, 32'h0000_0000, 6'd32);
		load_symbol(8'h55, 32'hA5A5_A5A5, 6'd13);
		load_symbol(8'h2A, 32'h1234_5678, 6'd40);
		load_symbol(8'h33, 32'hFEDC_BA98, 6'd63);
		load_symbol(8'h7F, 32'hDEAD_BEEF, 6'd0);
		encode_symbol(8'h00);
		encode_symbol(8'hFF);
		encode_symbol(8'h80);
		encode_symbol(8'h7F);
		send_request(REQ_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		encode_symbol(8'h55);
		flush_stream();
		encode_symbol(8'h2A);
		encode_symbol(8'h33);
		flush_stream();
		encode_symbol(8'h00);
		flush_stream();
	endtask

	function automatic logic [5:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 6'd0;
		else if (r < 75)
			return 6'($urandom_range(1, 10));
		else if (r < 92)
			return 6'($urandom_range(11, 20));
		return 6'($urandom_range(21, 32));
	endfunction

	// Each round loads part of the table, then encodes a stream mostly drawn
	// from loaded symbols, with flushes, stray symbols and noise mixed in.
	task automatic test_random_streams();
		int r;
		int nload;
		for (int round = 0; round < RAND_ROUNDS; round++) begin
			loaded_syms.delete();
			nload = $urandom_range(6, 16);
			repeat (nload)
				load_symbol(8'($urandom), $urandom, pick_length());
			repeat (30) begin
				r = $urandom_range(0, 99);
				if (r < 80 && loaded_syms.size() > 0)
					encode_symbol(8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
				else if (r < 85)
					encode_symbol(8'($urandom));
				else if (r < 92)
					flush_stream();
				else if (r < 96)
					send_request(REQ_UNKNOWN, 8'($urandom), $urandom, 6'($urandom));
				else
					load_symbol(8'($urandom), $urandom, pick_length());
			end
			flush_stream();
		end
	endtask

	// The receiver stops popping while full-length codes keep arriving, so
	// every queue inside the block fills and the request side stalls.
	task automatic test_backpressure();
		load_symbol(8'hC3, $urandom, 6'd32);
		hold_request = 1;
		repeat (40)
			encode_symbol(8'hC3);
		flush_stream();
	endtask

	// Receiver: steady, random or periodic popping, with long hold-offs on
	// request from the test sequence.
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       phase;
		int       hold_cnt;
		rx_mode = RX_STEADY;
		mode_left = 0;
		phase = 0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_cnt = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				phase++;
				case (rx_mode)
					RX_STEADY: pop <= 1'b1;
					RX_RANDOM: pop <= ($urandom_range(0, 99) < 65);
					default: pop <= (phase % 4 != 0);
				endcase
			end
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (byte_q.size() == 0) begin
				$error("unexpected result: out_byte %0h flush_done %0b", out_byte, flush_done);
				errors++;
			end else begin
				want = byte_q.pop_front();
				check_field("out_byte", want.data, out_byte);
				check_field("byte_valid", want.valid, byte_valid);
				check_field("pad_count", want.pad, pad_count);
				check_field("flush_done", want.done, flush_done);
				check_field("last", want.lst, last);
			end
		end
	end

	// Ends the run if neither side moves a request or a result for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("huffman_table_encoder verification failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_streams();
		test_backpressure();
		push <= 1'b0;
		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("huffman_table_encoder verification clean");
		else
			$display("huffman_table_encoder verification failed");
		$finish;
	end

endmodule
